// ----- rtl/dpll_pkg.sv -----
// Package for the PI-filtered digital PLL: widths, register codes, reset values,
// command/status structs, saturation and sine-table functions.
// No dependencies.
package dpll_pkg;

	localparam int unsigned SAMPLE_BITS        = 16;
	localparam int unsigned FRAC_BITS          = SAMPLE_BITS - 1;
	localparam int unsigned GAIN_SHIFT         = FRAC_BITS + 16 - 24;
	localparam int unsigned SINE_ADDR_BITS_DEF = 10;
	localparam int unsigned CFG_DATA_W         = 32;
	localparam int unsigned CFG_IDX_W          = 2;
	localparam int unsigned MUL_W              = 33;
	localparam int unsigned PROD_W             = 2 * MUL_W;

	localparam logic [15:0] PROP_GAIN_RST  = 16'd17479;
	localparam logic [15:0] INTEG_GAIN_RST = 16'd1167;
	localparam logic [23:0] NCO_GAIN_RST   = 24'd65536;
	localparam logic [31:0] PHASE_STEP_RST = 32'd429496730;

	// 1/(2*pi) in Q0.32
	localparam logic [31:0] INV_TWO_PI_Q32 = 32'd683565276;

	localparam logic [63:0] SIN_C1  = 64'd1686629713;
	localparam logic [63:0] SIN_C3  = 64'd693598669;
	localparam logic [63:0] SIN_C5  = 64'd85569306;
	localparam logic [63:0] SIN_C7  = 64'd5026995;
	localparam logic [63:0] SIN_C9  = 64'd172272;
	localparam logic [63:0] Q30_ONE = 64'd1 << 30;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROP_GAIN  = 2'd0,
		REG_INTEG_GAIN = 2'd1,
		REG_NCO_GAIN   = 2'd2,
		REG_PHASE_STEP = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] cos_sample;
		logic signed [SAMPLE_BITS-1:0] neg_sine;
		logic signed [SAMPLE_BITS-1:0] phase_error;
		logic signed [31:0]            filter_out;
		logic        [31:0]            phase_offset;
	} out_item_t;

	typedef enum logic [2:0] {
		OP_ERR,
		OP_KI,
		OP_KP,
		OP_K0,
		OP_INV
	} mul_op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ERR,
		S_KI,
		S_KP,
		S_FILT,
		S_K0,
		S_INV,
		S_DONE
	} state_t;

	typedef struct packed {
		logic    take;
		mul_op_t op;
		logic    mul_en;
		logic    err_en;
		logic    integ_en;
		logic    filt_en;
		logic    sin_en;
		logic    cos_en;
		logic    rom_cos;
		logic    out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_sts_t;

	function automatic logic signed [31:0] sat32(input logic signed [32:0] x);
		logic signed [31:0] r;
		if (x[32] != x[31])
			r = x[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		else
			r = x[31:0];
		return r;
	endfunction

	// sin(2*pi*addr/2^abits), quarter-wave polynomial in Q2.30, rounded to Q1.15
	function automatic logic signed [SAMPLE_BITS-1:0] sine_entry(
		input int unsigned addr,
		input int unsigned abits
	);
		int unsigned a;
		int unsigned quad;
		logic [63:0] y;
		logic [63:0] y2;
		logic [63:0] t;
		logic [63:0] r;
		logic [63:0] v;
		logic [63:0] maxv;
		a    = addr & ((32'd1 << abits) - 32'd1);
		quad = a >> (abits - 2);
		y    = 64'(a & ((32'd1 << (abits - 2)) - 32'd1)) << (30 - (abits - 2));
		if ((quad & 32'd1) != 0)
			y = Q30_ONE - y;
		y2   = (y * y) >> 30;
		t    = SIN_C9;
		t    = SIN_C7 - ((y2 * t) >> 30);
		t    = SIN_C5 - ((y2 * t) >> 30);
		t    = SIN_C3 - ((y2 * t) >> 30);
		t    = SIN_C1 - ((y2 * t) >> 30);
		r    = (y * t) >> 30;
		v    = (r + (64'd1 << (30 - FRAC_BITS - 1))) >> (30 - FRAC_BITS);
		maxv = (64'd1 << FRAC_BITS) - 64'd1;
		if (v > maxv)
			v = maxv;
		if ((quad & 32'd2) != 0)
			v = -v;
		return SAMPLE_BITS'(v);
	endfunction

endpackage

// ----- rtl/dpll_if.sv -----
// Stream interfaces for the PLL sample and result channels.
// Depends on dpll_pkg for the payload types.
interface dpll_in_if import dpll_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface dpll_out_if import dpll_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

// ----- rtl/dpll_sine_rom.sv -----
// Sine lookup table with registered read, built at elaboration.
// Depends on dpll_pkg (sine_entry).
module dpll_sine_rom import dpll_pkg::*; #(
	parameter int unsigned ADDR_BITS = SINE_ADDR_BITS_DEF
) (
	input  logic                          clk,
	input  logic [ADDR_BITS-1:0]          addr,
	output logic signed [SAMPLE_BITS-1:0] data
);

	logic signed [SAMPLE_BITS-1:0] rom_tbl [2**ADDR_BITS];
	logic signed [SAMPLE_BITS-1:0] data_q;

	for (genvar i = 0; i < 2**ADDR_BITS; i++) begin : g_tbl
		assign rom_tbl[i] = sine_entry(i, ADDR_BITS);
	end

	always_ff @(posedge clk) begin
		data_q <= rom_tbl[addr];
	end

	assign data = data_q;

endmodule

// ----- rtl/dpll_datapath.sv -----
// PLL datapath: config registers, loop state, shared 33x33 multiplier,
// saturation, phase accumulators, sine table and result register.
// Depends on dpll_pkg, dpll_if, dpll_sine_rom.
module dpll_datapath import dpll_pkg::*; #(
	parameter int unsigned SINE_ADDR_BITS = SINE_ADDR_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dp_cmd_t               cmd,
	output dp_sts_t               sts,
	input  in_item_t              in_item,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	dpll_out_if.source            results
);

	localparam int unsigned ERR_SH_W = SAMPLE_BITS + 2;

	logic [15:0] kp_q;
	logic [15:0] ki_q;
	logic [23:0] k0_q;
	logic [31:0] step_q;

	logic signed [SAMPLE_BITS-1:0] s_q;
	logic signed [SAMPLE_BITS-1:0] ref_q;
	logic signed [SAMPLE_BITS-1:0] err_q;
	logic signed [SAMPLE_BITS-1:0] cos_q;
	logic signed [31:0]            integ_q;
	logic signed [31:0]            filt_q;
	logic        [31:0]            nom_q;
	logic        [31:0]            off_q;
	logic signed [PROD_W-1:0]      prod_q;
	out_item_t                     out_q;
	logic                          out_valid_q;

	logic signed [MUL_W-1:0]       mul_a;
	logic signed [MUL_W-1:0]       mul_b;
	logic signed [ERR_SH_W-1:0]    err_sh;
	logic signed [SAMPLE_BITS-1:0] err_next;
	logic signed [32:0]            gain_term;
	logic signed [32:0]            integ_sum;
	logic signed [32:0]            filt_sum;
	logic        [31:0]            new_off;
	logic        [31:0]            angle;
	logic [SINE_ADDR_BITS-1:0]     sin_addr;
	logic [SINE_ADDR_BITS-1:0]     cos_addr;
	logic [SINE_ADDR_BITS-1:0]     rom_addr;
	logic signed [SAMPLE_BITS-1:0] rom_data;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q   <= PROP_GAIN_RST;
			ki_q   <= INTEG_GAIN_RST;
			k0_q   <= NCO_GAIN_RST;
			step_q <= PHASE_STEP_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PROP_GAIN:  kp_q   <= cfg_data[15:0];
				REG_INTEG_GAIN: ki_q   <= cfg_data[15:0];
				REG_NCO_GAIN:   k0_q   <= cfg_data[23:0];
				REG_PHASE_STEP: step_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// detector product >> FRAC_BITS, clamp (only -1 * -1 overflows)
	assign err_sh = prod_q[2*SAMPLE_BITS:FRAC_BITS];
	always_comb begin
		if (err_sh > ERR_SH_W'((1 << FRAC_BITS) - 1))
			err_next = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		else if (err_sh < -ERR_SH_W'(1 << FRAC_BITS))
			err_next = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		else
			err_next = err_sh[SAMPLE_BITS-1:0];
	end

	// gain products fit 33 bits; floor shift into Q8.24
	assign gain_term = {{GAIN_SHIFT{prod_q[32]}}, prod_q[32:GAIN_SHIFT]};
	assign integ_sum = {integ_q[31], integ_q} + gain_term;
	assign filt_sum  = {integ_q[31], integ_q} + gain_term;

	// floor(p >> 16) mod 2^32 is just a bit slice of the product
	assign new_off = off_q + prod_q[47:16];

	// operand select for the shared multiplier
	always_comb begin
		case (cmd.op)
			OP_ERR: begin
				mul_a = {{(MUL_W-SAMPLE_BITS){s_q[SAMPLE_BITS-1]}}, s_q};
				mul_b = {{(MUL_W-SAMPLE_BITS){ref_q[SAMPLE_BITS-1]}}, ref_q};
			end
			OP_KI: begin
				mul_a = {{(MUL_W-16){1'b0}}, ki_q};
				mul_b = {{(MUL_W-SAMPLE_BITS){err_next[SAMPLE_BITS-1]}}, err_next};
			end
			OP_KP: begin
				mul_a = {{(MUL_W-16){1'b0}}, kp_q};
				mul_b = {{(MUL_W-SAMPLE_BITS){err_q[SAMPLE_BITS-1]}}, err_q};
			end
			OP_K0: begin
				mul_a = {filt_q[31], filt_q};
				mul_b = {{(MUL_W-24){1'b0}}, k0_q};
			end
			OP_INV: begin
				mul_a = {prod_q[55], prod_q[55:24]};
				mul_b = {1'b0, INV_TWO_PI_Q32};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en)
			prod_q <= mul_a * mul_b;
		if (cmd.take)
			s_q <= in_item.sample;
		if (cmd.err_en)
			err_q <= err_next;
		if (cmd.filt_en)
			filt_q <= sat32(filt_sum);
		if (cmd.cos_en)
			cos_q <= rom_data;
	end

	// loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
			nom_q   <= '0;
			off_q   <= '0;
			ref_q   <= '0;
		end else begin
			if (cmd.take)
				nom_q <= nom_q + step_q;
			if (cmd.integ_en)
				integ_q <= sat32(integ_sum);
			if (cmd.sin_en)
				ref_q <= -rom_data;
			if (cmd.out_load)
				off_q <= new_off;
		end
	end

	// lookup at new nominal phase plus the previous offset
	assign angle    = nom_q + off_q;
	assign sin_addr = angle[31 -: SINE_ADDR_BITS];
	assign cos_addr = sin_addr + SINE_ADDR_BITS'(1 << (SINE_ADDR_BITS - 2));
	assign rom_addr = cmd.rom_cos ? cos_addr : sin_addr;

	dpll_sine_rom #(
		.ADDR_BITS(SINE_ADDR_BITS)
	) u_rom (
		.clk (clk),
		.addr(rom_addr),
		.data(rom_data)
	);

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.cos_sample   <= cos_q;
			out_q.neg_sine     <= ref_q;
			out_q.phase_error  <= err_q;
			out_q.filter_out   <= filt_q;
			out_q.phase_offset <= new_off;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (results.ready)
			out_valid_q <= 1'b0;
	end

	assign results.valid   = out_valid_q;
	assign results.payload = out_q;
	assign sts.out_free    = !out_valid_q || results.ready;

endmodule

// ----- rtl/dpll_ctrl.sv -----
// PLL sequencer: walks one sample through the shared multiplier steps.
// Depends on dpll_pkg.
module dpll_ctrl import dpll_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_next;
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			S_IDLE: if (in_valid) state_next = S_ERR;
			S_ERR:  state_next = S_KI;
			S_KI:   state_next = S_KP;
			S_KP:   state_next = S_FILT;
			S_FILT: state_next = S_K0;
			S_K0:   state_next = S_INV;
			S_INV:  state_next = S_DONE;
			S_DONE: if (sts.out_free) state_next = S_IDLE;
			default: state_next = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.op   = OP_ERR;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
			end
			S_ERR: begin
				cmd.op     = OP_ERR;
				cmd.mul_en = 1'b1;
			end
			S_KI: begin
				cmd.op      = OP_KI;
				cmd.mul_en  = 1'b1;
				cmd.err_en  = 1'b1;
				cmd.sin_en  = 1'b1;
				cmd.rom_cos = 1'b1;
			end
			S_KP: begin
				cmd.op       = OP_KP;
				cmd.mul_en   = 1'b1;
				cmd.integ_en = 1'b1;
				cmd.cos_en   = 1'b1;
			end
			S_FILT: cmd.filt_en = 1'b1;
			S_K0: begin
				cmd.op     = OP_K0;
				cmd.mul_en = 1'b1;
			end
			S_INV: begin
				cmd.op     = OP_INV;
				cmd.mul_en = 1'b1;
			end
			S_DONE: cmd.out_load = sts.out_free;
			default: ;
		endcase
	end

endmodule

// ----- rtl/digital_pll_pi_loop.sv -----
// Top level of the digital PLL with multiplier phase detector and PI filter.
// Depends on dpll_pkg, dpll_if, dpll_ctrl, dpll_datapath.
//
// Usage:
//  - samples: one Q1.15 input sample per transfer (valid/ready).
//  - results: cosine, new negative-sine reference, phase error, PI filter
//    output (Q8.24) and updated phase offset, one result per sample.
//  - cfg_we/cfg_index/cfg_data: write-only gain and phase-step registers;
//    write only while no sample is in flight.
//  - One sample at a time: the sequencer takes each sample through the
//    single shared 33x33 multiplier, used five times per sample (detector,
//    ki, kp, k0, 1/(2*pi)), with the filter sum between kp and k0 and the
//    result load last; the next sample is accepted only back in idle.
//  - Sine and cosine come from a 2^SINE_ADDR_BITS-entry table, one
//    registered read per cycle, both reads overlapping the multiply steps.
//  - Reset: integrator, phase accumulators and sine reference go to zero,
//    gains to their defaults; no clearing pass, samples accepted at once.
//  - Stall: the result waits in the output register and the next sample is
//    still taken; the sequencer holds in its last step only if that result
//    has not gone out by then.
module digital_pll_pi_loop import dpll_pkg::*; #(
	parameter int unsigned SINE_ADDR_BITS = SINE_ADDR_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	dpll_in_if.sink               samples,
	dpll_out_if.source            results,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	// sequencer: one sample at a time
	dpll_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(samples.valid),
		.in_ready(samples.ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	// arithmetic, loop state, table and result register
	dpll_datapath #(
		.SINE_ADDR_BITS(SINE_ADDR_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_item  (samples.payload),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.results  (results)
	);

	// one sample in flight: ready drops after each input transfer
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		samples.valid && samples.ready |=> !samples.ready)
		else $error("sample accepted while previous one in flight");

	// a new result only appears from a result load
	a_valid_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(results.valid) |-> $past(cmd.out_load))
		else $error("result valid without a load");

	// never overwrite a result that has not been transferred
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!results.valid || results.ready))
		else $error("pending result overwritten");

	// no multiply step while idle
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		samples.ready |-> !cmd.mul_en && !cmd.out_load)
		else $error("datapath active while idle");

endmodule
